>>> design/page_table_walk_translate_macros.svh
// assertion macros for the page table walker
// used by the top level only, needs i_clk and i_rst_n in scope
`ifndef PAGE_TABLE_WALK_TRANSLATE_MACROS_SVH
`define PAGE_TABLE_WALK_TRANSLATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTWT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PTWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ptwt_pkg.sv
// types, codes and helpers shared by the page table walker
// no dependencies
package ptwt_pkg;

    localparam int unsigned ADDR_W      = 52;
    localparam int unsigned VIRT_W      = 48;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned IDX_W       = 9;
    localparam int unsigned RIGHTS_W    = 3;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned LARGE_SHIFT = 21;
    localparam int unsigned ENT_PRESENT = 0;
    localparam int unsigned ENT_HUGE    = 7;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RIGHTS_W-1:0] ALL_RIGHTS = '1;

    typedef enum logic [1:0] {
        KIND_READ = 2'd0,
        KIND_DONE = 2'd1,
        KIND_SPUR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        LVL_PT   = 2'd0,
        LVL_PD   = 2'd1,
        LVL_PDPT = 2'd2,
        LVL_PML4 = 2'd3
    } t_level;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] root_addr;
        logic [VIRT_W-1:0] virt_addr;
        logic [DATA_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   read_addr;
        logic [ADDR_W-1:0]   phys_addr;
        logic                fault;
        logic [RIGHTS_W-1:0] access_flags;
        logic                large_page;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic                is_start;
        logic                no_root;
        logic                present;
        logic                huge;
        logic [RIGHTS_W-1:0] rights;
        logic [ADDR_W-1:0]   base;
        logic [VIRT_W-1:0]   virt;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
    } t_q_status;

    function automatic logic [IDX_W-1:0] entry_index(logic [VIRT_W-1:0] virt, t_level lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = virt[47:39];
            LVL_PDPT: idx = virt[38:30];
            LVL_PD:   idx = virt[29:21];
            default:  idx = virt[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> design/ptwt_chan_if.sv
// valid/ready channel carrying one item of any packed type
// payload types come from ptwt_pkg
interface ptwt_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ptwt_front.sv
// front stage: takes items, masks addresses and decodes entry bits
// depends on ptwt_pkg and ptwt_chan_if
module ptwt_front #(
    parameter int unsigned PHYS_ADDR_BITS = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptwt_chan_if.sink         i_req,
    output logic              o_cmd_valid,
    output ptwt_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_ready
);
    localparam int unsigned AW = ptwt_pkg::ADDR_W;
    localparam int unsigned PS = ptwt_pkg::PAGE_SHIFT;
    localparam logic [AW-1:0] PHYS_MASK = AW'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
    localparam logic [AW-1:0] BASE_MASK = {PHYS_MASK[AW-1:PS], {PS{1'b0}}};

    logic              r_valid;
    ptwt_pkg::t_cmd    r_cmd;
    ptwt_pkg::t_cmd    n_cmd;
    logic [AW-1:0]     raw_addr;

    assign i_req.ready = !r_valid || i_cmd_ready;

    always_comb begin
        raw_addr       = i_req.data.req_type ? i_req.data.read_data[AW-1:0]
                                             : i_req.data.root_addr;
        n_cmd.is_start = !i_req.data.req_type;
        n_cmd.base     = raw_addr & BASE_MASK;
        n_cmd.no_root  = (n_cmd.base == '0);
        n_cmd.present  = i_req.data.read_data[ptwt_pkg::ENT_PRESENT];
        n_cmd.huge     = i_req.data.read_data[ptwt_pkg::ENT_HUGE];
        n_cmd.rights   = i_req.data.read_data[ptwt_pkg::RIGHTS_W-1:0];
        n_cmd.virt     = i_req.data.virt_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

>>> design/ptwt_queue.sv
// short queue between front and back
// depends on ptwt_pkg
module ptwt_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    input  ptwt_pkg::t_cmd       i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output ptwt_pkg::t_cmd       o_pop_data,
    input  logic                 i_pop_ready,
    output ptwt_pkg::t_q_status  o_status
);
    localparam int unsigned PW    = ptwt_pkg::PTR_W;
    localparam int unsigned CW    = ptwt_pkg::CNT_W;
    localparam int unsigned DEPTH = ptwt_pkg::QUEUE_DEPTH;

    ptwt_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    assign o_push_ready = !o_status.full;
    assign o_pop_valid  = !o_status.empty;
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule

>>> design/ptwt_back.sv
// back stage: walk state, next read address or final translation
// depends on ptwt_pkg and ptwt_chan_if
module ptwt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  ptwt_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    ptwt_chan_if.source     o_rsp
);
    localparam int unsigned AW = ptwt_pkg::ADDR_W;
    localparam int unsigned VW = ptwt_pkg::VIRT_W;
    localparam int unsigned RW = ptwt_pkg::RIGHTS_W;
    localparam int unsigned PS = ptwt_pkg::PAGE_SHIFT;
    localparam int unsigned LS = ptwt_pkg::LARGE_SHIFT;
    localparam int unsigned IW = ptwt_pkg::IDX_W;

    logic                r_busy;
    ptwt_pkg::t_level    r_level;
    logic [VW-1:0]       r_virt;
    logic [RW-1:0]       r_rights;
    logic                r_out_valid;
    ptwt_pkg::t_out_item r_out;

    logic                n_busy;
    ptwt_pkg::t_level    n_level;
    logic [VW-1:0]       n_virt;
    logic [RW-1:0]       n_rights;
    ptwt_pkg::t_out_item n_out;
    logic [RW-1:0]       and_rights;
    logic                take;

    assign o_cmd_ready = !r_out_valid || o_rsp.ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign and_rights  = r_rights & i_cmd.rights;

    always_comb begin
        n_busy   = r_busy;
        n_level  = r_level;
        n_virt   = r_virt;
        n_rights = r_rights;
        n_out    = '0;
        if (i_cmd.is_start) begin
            n_virt   = i_cmd.virt;
            n_rights = ptwt_pkg::ALL_RIGHTS;
            if (i_cmd.no_root) begin
                n_busy      = 1'b0;
                n_level     = ptwt_pkg::LVL_PT;
                n_out.kind  = ptwt_pkg::KIND_DONE;
                n_out.fault = 1'b1;
            end else begin
                n_busy          = 1'b1;
                n_level         = ptwt_pkg::LVL_PML4;
                n_out.kind      = ptwt_pkg::KIND_READ;
                n_out.read_addr = i_cmd.base | {{(AW-IW-3){1'b0}},
                    ptwt_pkg::entry_index(i_cmd.virt, ptwt_pkg::LVL_PML4), 3'b000};
            end
        end else if (!r_busy) begin
            n_out.kind = ptwt_pkg::KIND_SPUR;
        end else if (!i_cmd.present) begin
            n_busy      = 1'b0;
            n_level     = ptwt_pkg::LVL_PT;
            n_out.kind  = ptwt_pkg::KIND_DONE;
            n_out.fault = 1'b1;
        end else begin
            n_rights = and_rights;
            if (r_level == ptwt_pkg::LVL_PD && i_cmd.huge) begin
                n_busy             = 1'b0;
                n_level            = ptwt_pkg::LVL_PT;
                n_out.kind         = ptwt_pkg::KIND_DONE;
                n_out.phys_addr    = {i_cmd.base[AW-1:LS], r_virt[LS-1:0]};
                n_out.access_flags = and_rights;
                n_out.large_page   = 1'b1;
            end else if (r_level == ptwt_pkg::LVL_PT) begin
                n_busy             = 1'b0;
                n_out.kind         = ptwt_pkg::KIND_DONE;
                n_out.phys_addr    = {i_cmd.base[AW-1:PS], r_virt[PS-1:0]};
                n_out.access_flags = and_rights;
            end else begin
                n_level         = ptwt_pkg::t_level'(r_level - 2'd1);
                n_out.kind      = ptwt_pkg::KIND_READ;
                n_out.read_addr = i_cmd.base | {{(AW-IW-3){1'b0}},
                    ptwt_pkg::entry_index(r_virt, n_level), 3'b000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_level     <= ptwt_pkg::LVL_PT;
            r_virt      <= '0;
            r_rights    <= ptwt_pkg::ALL_RIGHTS;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
            if (take) begin
                r_busy   <= n_busy;
                r_level  <= n_level;
                r_virt   <= n_virt;
                r_rights <= n_rights;
                r_out    <= n_out;
            end
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule

>>> design/page_table_walk_translate.sv
// Four-level page table walker. Each request or memory response item yields exactly one
// result item: a read request for the next entry, a finished walk (translation or fault) or
// a notice that a response arrived with no walk running. One item is taken every cycle while the
// queue is not full; a result passes through the front register, a queue entry and the output
// register, and waits in the output register only while the result side stalls. The queue lets
// the input side keep accepting, until the queue is full, while a result waits to be taken.
// depends on ptwt_pkg, ptwt_chan_if, ptwt_front, ptwt_queue, ptwt_back and the macro header
`include "page_table_walk_translate_macros.svh"

module page_table_walk_translate #(
    parameter int unsigned PHYS_ADDR_BITS = 52
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptwt_chan_if.sink   i_req,
    ptwt_chan_if.source o_rsp
);
    logic                 front_valid;
    ptwt_pkg::t_cmd       front_cmd;
    logic                 front_ready;
    logic                 q_valid;
    ptwt_pkg::t_cmd       q_cmd;
    logic                 q_ready;
    ptwt_pkg::t_q_status  q_status;

    ptwt_front #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    ptwt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_cmd),
        .i_pop_ready  (q_ready),
        .o_status     (q_status)
    );

    ptwt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_rsp       (o_rsp)
    );

    `PTWT_ASSERT_NOW(a_queue_bound, 1'b1,
        q_status.count <= ptwt_pkg::CNT_W'(ptwt_pkg::QUEUE_DEPTH),
        "queue count beyond depth")
    `PTWT_ASSERT_NOW(a_fault_clean, o_rsp.valid && o_rsp.data.fault,
        o_rsp.data.kind == ptwt_pkg::KIND_DONE && o_rsp.data.phys_addr == '0
            && o_rsp.data.access_flags == '0,
        "fault result carries data")
    `PTWT_ASSERT_NOW(a_read_only_addr, o_rsp.valid && o_rsp.data.kind != ptwt_pkg::KIND_READ,
        o_rsp.data.read_addr == '0, "read address on a non-read result")
    `PTWT_ASSERT_NOW(a_large_done, o_rsp.valid && o_rsp.data.large_page,
        o_rsp.data.kind == ptwt_pkg::KIND_DONE && !o_rsp.data.fault,
        "large page flag off a translation")
    `PTWT_ASSERT_NEXT(a_full_stalls, front_valid && q_status.full && !q_ready,
        front_valid && $stable(front_cmd), "front item lost while queue full")
endmodule
